// ===== rtl/ndap_pkg.sv =====
// ---------------------------------------------------------------------------
// ndap_pkg
// types, register indexes and helper functions for the permute address unit
// ---------------------------------------------------------------------------
package ndap_pkg;

    localparam int REG_DIMS       = 4;
    localparam int DIV_BITS       = 32;
    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES_PER_DIV = DIV_BITS / BITS_PER_STAGE;
    localparam int DIV_STAGES     = REG_DIMS * STAGES_PER_DIV;
    localparam int PIPE_STAGES    = DIV_STAGES + REG_DIMS;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_0        = 3'd0;
    localparam logic [2:0] REG_SIZE_1        = 3'd1;
    localparam logic [2:0] REG_SIZE_2        = 3'd2;
    localparam logic [2:0] REG_SIZE_3        = 3'd3;
    localparam logic [2:0] REG_DIM_COUNT     = 3'd4;
    localparam logic [2:0] REG_PERM_MAP      = 3'd5;
    localparam logic [2:0] REG_ELEMENT_COUNT = 3'd6;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_PERM  = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    typedef struct packed {
        logic [31:0]                id;
        logic [31:0]                quo;   // quotient under way, later accumulator
        logic [15:0]                rem;
        logic                       ovf;
        logic [REG_DIMS-1:0][15:0]  dig;
    } stage_t;

    // a size of zero counts as one
    function automatic logic [15:0] eff_size(input logic [15:0] s);
        eff_size = (s == 16'd0) ? 16'd1 : s;
    endfunction

    // four restoring division steps, returns {quotient, remainder}
    function automatic logic [47:0] div_step(input logic [31:0] q_in,
                                             input logic [15:0] r_in,
                                             input logic [15:0] s);
        logic [31:0] q;
        logic [16:0] r;
        q = q_in;
        r = {1'b0, r_in};
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            r = {r[15:0], q[31]};
            q = {q[30:0], 1'b0};
            if (r >= {1'b0, s})
            begin
                r    = r - {1'b0, s};
                q[0] = 1'b1;
            end
        end
        div_step = {q, r[15:0]};
    endfunction

endpackage

// ===== rtl/nd_array_permute_address_unit.sv =====
// ---------------------------------------------------------------------------
// nd_array_permute_address_unit
// destination address generator for transposing an n-dimensional array
// ---------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata[31:0] element_id
//  m_axis    | out       | tdata[31:0] dest_id, [33:32] status, rest zero
//  cfg       | in        | write enable, register index, write data
//
// one transfer per cycle in and out while m_axis does not stall; an input passes
// the digit split (four 32-bit divisions, four quotient bits per stage), then
// four multiply-accumulate stages and the output register
// reset clears the pipeline valid bits and loads the register defaults
// a stall on m_axis freezes the whole pipeline; s_axis_tready drops with it
// ---------------------------------------------------------------------------
module nd_array_permute_address_unit
    import ndap_pkg::*;
#(
    parameter int MAX_DIMS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] dest_id, [33:32] status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int LIM = (MAX_DIMS < REG_DIMS) ? MAX_DIMS : REG_DIMS;

    // configuration registers
    logic [REG_DIMS-1:0][15:0] size_reg;
    logic [2:0]                dim_count_reg;
    logic [7:0]                perm_map_reg;
    logic [31:0]               element_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg          <= {REG_DIMS{16'd1}};
            dim_count_reg     <= 3'd1;
            perm_map_reg      <= 8'd228;
            element_count_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SIZE_0:        size_reg[0]       <= cfg_wdata[15:0];
                REG_SIZE_1:        size_reg[1]       <= cfg_wdata[15:0];
                REG_SIZE_2:        size_reg[2]       <= cfg_wdata[15:0];
                REG_SIZE_3:        size_reg[3]       <= cfg_wdata[15:0];
                REG_DIM_COUNT:     dim_count_reg     <= cfg_wdata[2:0];
                REG_PERM_MAP:      perm_map_reg      <= cfg_wdata[7:0];
                REG_ELEMENT_COUNT: element_count_reg <= cfg_wdata;
                default:           ;   // unknown index ignored
            endcase
        end
    end

    // decoded configuration; the user must keep it static while items are in flight, the block does not enforce this
    logic [2:0]                n_dims;
    logic [2:0]                n_m1;
    logic                      perm_bad;
    logic [REG_DIMS-1:0][1:0]  src_sel;
    logic [REG_DIMS-1:0][15:0] eff;

    always_comb
    begin
        logic [REG_DIMS-1:0] seen;
        logic [1:0]          e;
        logic [2:0]          idx;
        if (dim_count_reg == 3'd0)
            n_dims = 3'd1;
        else if (dim_count_reg > 3'(LIM))
            n_dims = 3'(LIM);
        else
            n_dims = dim_count_reg;
        n_m1 = n_dims - 3'd1;

        // bijection check over the first n entries
        seen     = '0;
        perm_bad = 1'b0;
        for (int k = 0; k < REG_DIMS; k++)
        begin
            e = perm_map_reg[2*k +: 2];
            if (3'(k) < n_dims)
            begin
                if ({1'b0, e} >= n_dims || seen[e])
                    perm_bad = 1'b1;
                seen[e] = 1'b1;
            end
        end

        // source dimension for each destination position
        for (int i = 0; i < REG_DIMS; i++)
        begin
            idx        = n_m1 - 3'(i);
            e          = perm_map_reg[2*idx[1:0] +: 2];
            src_sel[i] = 2'(n_m1 - {1'b0, e});
            eff[i]     = eff_size(size_reg[i]);
        end
    end

    // pipeline
    logic                     adv;
    logic [PIPE_STAGES-1:0]   valid_reg;
    stage_t                   stage_reg  [PIPE_STAGES];
    stage_t                   stage_in   [PIPE_STAGES];
    stage_t                   stage_next [PIPE_STAGES];
    logic                     out_valid_reg;
    logic [31:0]              out_dest_reg;
    logic [1:0]               out_status_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    assign stage_in[0] = '{id: s_axis_tdata, quo: s_axis_tdata, default: '0};

    genvar k;
    generate
        for (k = 0; k < PIPE_STAGES; k++)
        begin : g_stage
            if (k > 0)
            begin : g_link
                assign stage_in[k] = stage_reg[k-1];
            end

            if (k < DIV_STAGES)
            begin : g_div
                // digit split: stage k works on dimension k / STAGES_PER_DIV
                localparam int D = k / STAGES_PER_DIV;
                always_comb
                begin
                    logic [47:0] qr;
                    qr            = div_step(stage_in[k].quo, stage_in[k].rem, eff[D]);
                    stage_next[k] = stage_in[k];
                    stage_next[k].quo = qr[47:16];
                    if ((k % STAGES_PER_DIV) == STAGES_PER_DIV - 1)
                    begin
                        stage_next[k].dig[D] = qr[15:0];
                        stage_next[k].rem    = 16'd0;
                    end
                    else
                        stage_next[k].rem = qr[15:0];
                end
            end
            else
            begin : g_mac
                // recombination, slowest destination position first
                localparam int I = REG_DIMS - 1 - (k - DIV_STAGES);
                always_comb
                begin
                    logic [31:0] acc;
                    logic        ovf;
                    logic [15:0] s;
                    logic [15:0] d;
                    logic [47:0] prod;
                    logic [48:0] sum;
                    acc = (k == DIV_STAGES) ? 32'd0 : stage_in[k].quo;
                    ovf = (k == DIV_STAGES) ? 1'b0  : stage_in[k].ovf;
                    if (3'(I) < n_dims)
                    begin
                        s = eff[src_sel[I]];
                        d = stage_in[k].dig[src_sel[I]];
                    end
                    else
                    begin
                        s = 16'd1;
                        d = 16'd0;
                    end
                    prod = 48'(acc) * 48'(s);
                    sum  = {1'b0, prod} + 49'(d);
                    stage_next[k]     = stage_in[k];
                    stage_next[k].quo = sum[31:0];
                    stage_next[k].ovf = ovf | (|sum[48:32]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    stage_reg[k] <= stage_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], s_axis_tvalid};
    end

    // output register: range check and status
    logic [31:0] dest_next;
    logic [1:0]  status_next;

    always_comb
    begin
        stage_t last;
        last = stage_reg[PIPE_STAGES-1];
        if (n_dims == 3'd1)
        begin
            // single dimension: identity mapping
            dest_next   = last.id;
            status_next = (last.id >= element_count_reg) ? STATUS_RANGE : STATUS_OK;
        end
        else if (perm_bad)
        begin
            dest_next   = 32'd0;
            status_next = STATUS_BAD_PERM;
        end
        else
        begin
            dest_next   = last.quo;
            status_next = (last.ovf || last.quo >= element_count_reg) ?
                          STATUS_RANGE : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[PIPE_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_dest_reg   <= dest_next;
            out_status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_dest_reg};

endmodule
